>>> sv/ict_pkg.sv
// Package with the payload types, status codes and cell operations of the interval cover tracker.
package ict_pkg;

   typedef struct packed {
      logic [31:0] range_first;
      logic [31:0] range_last;
   } req_type;

   typedef struct packed {
      logic [31:0] uncovered_count;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_EVAL,
      OP_INSERT,
      OP_MERGE,
      OP_COMPACT
   } cell_op_type;

endpackage

>>> sv/ict_cell.sv
// One table cell: holds a stored interval, classifies it against a range and moves it along the row.
module ict_cell #(
   parameter int PW = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ict_pkg::cell_op_type op,
   input  logic [PW-1:0]       lo,
   input  logic [PW-1:0]       hi,
   input  logic [PW-1:0]       new_start,
   input  logic [PW-1:0]       new_stop,
   input  logic                prev_valid,
   input  logic [PW-1:0]       prev_start,
   input  logic [PW-1:0]       prev_stop,
   input  logic                prev_bef,
   input  logic                prev_ovl,
   input  logic                next_valid,
   input  logic [PW-1:0]       next_start,
   input  logic [PW-1:0]       next_stop,
   input  logic                next_ovl,
   output logic                cell_valid,
   output logic [PW-1:0]       cell_start,
   output logic [PW-1:0]       cell_stop,
   output logic                cell_ovl,
   output logic                cell_bef
);
   import ict_pkg::*;

   logic          valid_ff, valid_in;
   logic [PW-1:0] start_ff, start_in;
   logic [PW-1:0] stop_ff, stop_in;
   logic          ovl_ff, ovl_in;
   logic          bef_ff, bef_in;
   logic          first;
   logic [PW:0]   start_x, stop_p1, lo_x, hi_p1;

   assign first   = ovl_ff & ~prev_ovl;
   assign start_x = {1'b0, start_ff};
   assign stop_p1 = {1'b0, stop_ff} + {{PW{1'b0}}, 1'b1};
   assign lo_x    = {1'b0, lo};
   assign hi_p1   = {1'b0, hi} + {{PW{1'b0}}, 1'b1};

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      ovl_in   = ovl_ff;
      bef_in   = bef_ff;
      case (op)
         OP_EVAL: begin
            ovl_in = valid_ff & (start_x <= hi_p1) & (stop_p1 >= lo_x);
            bef_in = valid_ff & (stop_p1 < lo_x);
         end
         OP_INSERT: begin
            if (!bef_ff) begin
               if (prev_bef) begin
                  valid_in = 1'b1;
                  start_in = new_start;
                  stop_in  = new_stop;
               end else begin
                  valid_in = prev_valid;
                  start_in = prev_start;
                  stop_in  = prev_stop;
               end
               ovl_in = 1'b0;
            end
         end
         OP_MERGE: begin
            if (first) begin
               start_in = new_start;
               stop_in  = new_stop;
            end
         end
         OP_COMPACT: begin
            if (!prev_bef) begin
               valid_in = next_valid;
               start_in = next_start;
               stop_in  = next_stop;
               ovl_in   = next_ovl;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ovl_ff   <= 1'b0;
         bef_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ovl_ff   <= ovl_in;
         bef_ff   <= bef_in;
      end
      start_ff <= start_in;
      stop_ff  <= stop_in;
   end

   assign cell_valid = valid_ff;
   assign cell_start = start_ff;
   assign cell_stop  = stop_ff;
   assign cell_ovl   = ovl_ff;
   assign cell_bef   = bef_ff;

endmodule

>>> sv/interval_cover_tracker_core.sv
// Top level of the interval cover tracker: control sequencer, covered total and the row of cells.
//
// Channel   Direction  Handshake                       Payload
// req       in         start high while busy low       req_data (range_first, range_last)
// rsp       out        rsp_strobe, one cycle           rsp_data (uncovered_count, status)
// csr       in         csr_valid and csr_ready         csr_data (line_length)
//
// Busy spans the evaluate, calculate and respond states, with compact states between for
// absorbed stored intervals beyond the first, as the row of cells closes one gap per cycle.
// The result appears in the same cycle busy falls, and a new transaction may start then.
// Reset empties the table, clears the covered total and sets the line length to all ones.
// The receiver cannot stall results, so nothing inside waits on the output side.
module interval_cover_tracker_core #(
   parameter int MAX_INTERVALS = 16,
   parameter int POS_WIDTH     = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ict_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ict_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import ict_pkg::*;

   localparam int PW = POS_WIDTH;
   localparam int N  = MAX_INTERVALS;
   localparam logic [63:0] LINE_RESET = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_CALC,
      S_COMPACT,
      S_RESP
   } state_type;

   state_type     state_ff;
   logic [PW-1:0] lo_ff, hi_ff, line_ff, covered_ff;
   logic [1:0]    status_ff;
   logic          rsp_strobe_ff;
   rsp_type       rsp_data_ff;

   cell_op_type   op;
   logic [PW-1:0] start_w [N];
   logic [PW-1:0] stop_w  [N];
   logic [N-1:0]  valid_v, ovl_v, bef_v, f_v, l_v, fd_v;
   logic          any_ovl, full, more_d, bad;
   logic [PW-1:0] sf, sl, el, sd, ed, ml, mr, unc;
   logic [63:0]   first_ext, last_ext, csr_ext, unc_ext;

   assign first_ext = {32'd0, req_data.range_first};
   assign last_ext  = {32'd0, req_data.range_last};
   assign csr_ext   = {32'd0, csr_data};

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_cell
         logic          p_valid, p_bef, p_ovl, n_valid, n_ovl;
         logic [PW-1:0] p_start, p_stop, n_start, n_stop;
         if (k == 0) begin : g_head
            assign p_valid = 1'b0;
            assign p_start = '0;
            assign p_stop  = '0;
            assign p_bef   = 1'b1;
            assign p_ovl   = 1'b0;
         end else begin : g_mid
            assign p_valid = valid_v[k-1];
            assign p_start = start_w[k-1];
            assign p_stop  = stop_w[k-1];
            assign p_bef   = bef_v[k-1];
            assign p_ovl   = ovl_v[k-1];
         end
         if (k == N - 1) begin : g_tail
            assign n_valid = 1'b0;
            assign n_start = '0;
            assign n_stop  = '0;
            assign n_ovl   = 1'b0;
         end else begin : g_body
            assign n_valid = valid_v[k+1];
            assign n_start = start_w[k+1];
            assign n_stop  = stop_w[k+1];
            assign n_ovl   = ovl_v[k+1];
         end
         ict_cell #(.PW(PW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (op),
            .lo         (lo_ff),
            .hi         (hi_ff),
            .new_start  (ml),
            .new_stop   (mr),
            .prev_valid (p_valid),
            .prev_start (p_start),
            .prev_stop  (p_stop),
            .prev_bef   (p_bef),
            .prev_ovl   (p_ovl),
            .next_valid (n_valid),
            .next_start (n_start),
            .next_stop  (n_stop),
            .next_ovl   (n_ovl),
            .cell_valid (valid_v[k]),
            .cell_start (start_w[k]),
            .cell_stop  (stop_w[k]),
            .cell_ovl   (ovl_v[k]),
            .cell_bef   (bef_v[k])
         );
      end
   endgenerate

   assign f_v     = ovl_v & ~(ovl_v << 1);
   assign l_v     = ovl_v & ~(ovl_v >> 1);
   assign fd_v    = (f_v << 1) & ovl_v;
   assign more_d  = |((f_v << 2) & ovl_v);
   assign any_ovl = |ovl_v;
   assign full    = valid_v[N-1] & ~any_ovl;
   assign bad     = (lo_ff == '0) || (lo_ff > hi_ff) || (hi_ff > line_ff);

   always_comb begin
      sf = '0;
      sl = '0;
      el = '0;
      sd = '0;
      ed = '0;
      for (int i = 0; i < N; i++) begin
         if (f_v[i]) begin
            sf = sf | start_w[i];
            el = el | (l_v[i] ? stop_w[i] : '0);
         end else if (l_v[i]) begin
            el = el | stop_w[i];
         end
         if (f_v[i]) begin
            sl = sl | stop_w[i];
         end
         if (fd_v[i]) begin
            sd = sd | start_w[i];
            ed = ed | stop_w[i];
         end
      end
   end

   assign ml  = (any_ovl && sf < lo_ff) ? sf : lo_ff;
   assign mr  = (any_ovl && el > hi_ff) ? el : hi_ff;
   assign unc = (covered_ff >= line_ff) ? '0 : line_ff - covered_ff;
   assign unc_ext = {{(64-PW){1'b0}}, unc};

   always_comb begin
      op = OP_HOLD;
      case (state_ff)
         S_EVAL: op = OP_EVAL;
         S_CALC: begin
            if (status_ff == ST_OK && !full) begin
               op = any_ovl ? OP_MERGE : OP_INSERT;
            end
         end
         S_COMPACT: op = OP_COMPACT;
         default: op = OP_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         status_ff     <= ST_OK;
         covered_ff    <= '0;
         line_ff       <= LINE_RESET[PW-1:0];
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_valid) begin
            line_ff <= csr_ext[PW-1:0];
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  lo_ff    <= first_ext[PW-1:0];
                  hi_ff    <= last_ext[PW-1:0];
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               status_ff <= bad ? ST_BAD : ST_OK;
               state_ff  <= S_CALC;
            end
            S_CALC: begin
               if (status_ff != ST_OK) begin
                  state_ff <= S_RESP;
               end else if (full) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_RESP;
               end else if (!any_ovl) begin
                  covered_ff <= covered_ff + (hi_ff - lo_ff) + {{(PW-1){1'b0}}, 1'b1};
                  state_ff   <= S_RESP;
               end else begin
                  covered_ff <= covered_ff + (mr - ml) - (sl - sf);
                  state_ff   <= (|fd_v) ? S_COMPACT : S_RESP;
               end
            end
            S_COMPACT: begin
               covered_ff <= covered_ff - (ed - sd) - {{(PW-1){1'b0}}, 1'b1};
               if (!more_d) begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               rsp_strobe_ff               <= 1'b1;
               rsp_data_ff.uncovered_count <= unc_ext[31:0];
               rsp_data_ff.status          <= status_ff;
               state_ff                    <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_v & (valid_v + {{(N-1){1'b0}}, 1'b1})) == '0)
      else $error("stored intervals are not packed from entry zero");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a transaction is still in progress");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule

>>> tb/interval_cover_tracker_core_tb.sv
// Testbench of the interval cover tracker: random and directed ranges checked against a predictor.
module interval_cover_tracker_core_tb;
   import ict_pkg::*;

   localparam int NUM_CELLS = 16;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [31:0] csr_data;

   interval_cover_tracker_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Predictor state.
   logic [31:0] line_len;
   logic [31:0] span_lo [NUM_CELLS];
   logic [31:0] span_hi [NUM_CELLS];
   logic        span_used [NUM_CELLS] = '{default: 1'b0};
   logic [31:0] covered = '0;

   req_type range_queue [$];
   rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      failed = 0;
   bit      hold_req;
   int      gap_left;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] uncovered_now();
      if (covered >= line_len) return '0;
      return line_len - covered;
   endfunction

   function automatic bit touches(logic [31:0] s, logic [31:0] e, logic [31:0] lo,
                                  logic [31:0] hi);
      return ({1'b0, s} <= {1'b0, hi} + 33'd1) && ({1'b0, e} + 33'd1 >= {1'b0, lo});
   endfunction

   function automatic rsp_type cover_range(req_type r);
      rsp_type res;
      logic [31:0] lo, hi, ml, mr, removed;
      logic [31:0] ns [NUM_CELLS];
      logic [31:0] ne [NUM_CELLS];
      int used, merged, n;
      bit placed;
      lo = r.range_first;
      hi = r.range_last;
      res.status = ST_OK;
      used = 0;
      merged = 0;
      if (lo == 0 || lo > hi || hi > line_len) res.status = ST_BAD;
      if (res.status == ST_OK) begin
         for (int k = 0; k < NUM_CELLS; k++) begin
            if (span_used[k]) begin
               used++;
               if (touches(span_lo[k], span_hi[k], lo, hi)) merged++;
            end
         end
         if (used - merged + 1 > NUM_CELLS) res.status = ST_FULL;
      end
      if (res.status == ST_OK) begin
         ml = lo;
         mr = hi;
         removed = 0;
         for (int k = 0; k < NUM_CELLS; k++) begin
            if (span_used[k] && touches(span_lo[k], span_hi[k], lo, hi)) begin
               if (span_lo[k] < ml) ml = span_lo[k];
               if (span_hi[k] > mr) mr = span_hi[k];
               removed += span_hi[k] - span_lo[k] + 1;
            end
         end
         n = 0;
         placed = 0;
         for (int k = 0; k < NUM_CELLS; k++) begin
            if (span_used[k] && !touches(span_lo[k], span_hi[k], lo, hi)) begin
               if (!placed && span_lo[k] > mr) begin
                  ns[n] = ml; ne[n] = mr; n++; placed = 1;
               end
               if (n < NUM_CELLS) begin
                  ns[n] = span_lo[k]; ne[n] = span_hi[k]; n++;
               end
            end
         end
         if (!placed && n < NUM_CELLS) begin
            ns[n] = ml; ne[n] = mr; n++;
         end
         for (int k = 0; k < NUM_CELLS; k++) begin
            span_used[k] = (k < n);
            if (k < n) begin
               span_lo[k] = ns[k];
               span_hi[k] = ne[k];
            end
         end
         covered = covered - removed + (mr - ml + 1);
      end
      res.uncovered_count = uncovered_now();
      return res;
   endfunction

   function automatic req_type make_range(logic [31:0] f, logic [31:0] l);
      req_type r;
      r.range_first = f;
      r.range_last = l;
      return r;
   endfunction

   function automatic void queue_range(req_type r);
      range_queue.insert(range_queue.size(), r);
   endfunction

   // Mostly valid ranges over a small window so that intervals merge and the table fills.
   function automatic req_type random_range(int window);
      logic [31:0] f, l, base;
      int pick;
      pick = $urandom_range(0, 19);
      base = (line_len > window) ? $urandom_range(0, 3) * (line_len / 4) : 0;
      if (pick == 0) return make_range($urandom, $urandom);
      if (pick == 1) return make_range(0, $urandom_range(0, window));
      f = base + $urandom_range(1, window);
      l = f + $urandom_range(0, (pick < 12) ? 2 : window / 4);
      if (pick == 2) return make_range(l + 1, f);
      if (f > line_len) f = line_len;
      if (pick != 3 && l > line_len) l = line_len;
      if (l < f) l = f;
      return make_range(f, l);
   endfunction

   task automatic write_line_length(logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      line_len = value;
   endtask

   task automatic wait_idle();
      while (range_queue.size() != 0 || expected_rsps.size() != 0 || busy || start)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (start && !busy) begin
         start <= 1'b0;
         gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (range_queue.size() != 0 && !hold_req) begin
            req_data <= range_queue[0];
            expected_rsps.insert(expected_rsps.size(), cover_range(range_queue.pop_front()));
            start <= 1'b1;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", rsp_data);
         end else begin
            if (rsp_data.uncovered_count !== expected_rsps[0].uncovered_count ||
                rsp_data.status !== expected_rsps[0].status) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected count %0d status %0d, got count %0d status %0d",
                     expected_rsps[0].uncovered_count, expected_rsps[0].status,
                     rsp_data.uncovered_count, rsp_data.status);
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   initial begin
      logic [31:0] lengths [4];
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_req = 0;
      line_len = 32'hFFFF_FFFF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ranges at the reset line length.
      queue_range(make_range(0, 5));
      queue_range(make_range(9, 3));
      queue_range(make_range(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_range(make_range(1, 1));
      queue_range(make_range(3, 3));
      queue_range(make_range(2, 2));
      for (int k = 0; k < 16; k++) queue_range(make_range(10 + 3 * k, 10 + 3 * k));
      queue_range(make_range(1, 32'hFFFF_FFFF));
      wait_idle();

      write_line_length(32'd1);
      queue_range(make_range(1, 2));
      queue_range(make_range(1, 1));
      wait_idle();

      // Pause the sender until the block has drained.
      write_line_length(32'd200);
      for (int k = 0; k < 30; k++) queue_range(random_range(200));
      while (range_queue.size() > 15) @(posedge clock);
      hold_req = 1;
      while (expected_rsps.size() != 0 || busy || start) @(posedge clock);
      repeat (5) @(posedge clock);
      hold_req = 0;
      wait_idle();

      lengths = '{32'd60, 32'd1000, 32'hFFFF_FFFF, 32'd5000};
      for (int p = 0; p < 4; p++) begin
         write_line_length(lengths[p]);
         for (int k = 0; k < 480; k++)
            queue_range(random_range(p == 2 ? 400 : 120));
         wait_idle();
      end
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
sv/ict_pkg.sv
sv/ict_cell.sv
sv/interval_cover_tracker_core.sv
tb/interval_cover_tracker_core_tb.sv
